// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BLC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BLC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define BLC_ASSERT(lbl, prop, msg)
`define BLC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/core/blc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breathing LED controller package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package blc_pkg;

   localparam int DUTY_BITS = 10;

   localparam int LEVEL_W = 10;
   localparam int STEP_W  = 4;
   localparam int HOLD_W  = 8;
   localparam int SDIV_W  = 5;
   localparam int DCNT_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [LEVEL_W-1:0] FULL_DUTY =
      LEVEL_W'(((1 << DUTY_BITS) - 1) & ((1 << LEVEL_W) - 1));

   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 10'd235;
   localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 10'd10;
   localparam logic [STEP_W-1:0]  STEP_RST      = 4'd2;
   localparam logic [HOLD_W-1:0]  HOLD_RST      = 8'd4;
   localparam logic [SDIV_W-1:0]  SDIV_RST      = 5'd4;
   localparam logic [SDIV_W-1:0]  SDIV_MAX      = 5'd16;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'b00,
      MODE_FAST = 2'b01,
      MODE_SLOW = 2'b10,
      MODE_FULL = 2'b11
   } mode_type;

   typedef enum logic [1:0] {
      APP_INIT    = 2'b00,
      APP_USB     = 2'b01,
      APP_READY   = 2'b10,
      APP_PROBLEM = 2'b11
   } app_type;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_MODE = 2'd1,
      KIND_APP  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LEVEL = 3'd0,
      CSR_MIN_LEVEL = 3'd1,
      CSR_STEP      = 3'd2,
      CSR_HOLD      = 3'd3,
      CSR_SLOW_DIV  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               going_up;
   } lvl_state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] max_level;
      logic [LEVEL_W-1:0] min_level;
      logic [STEP_W-1:0]  step;
   } lvl_cfg_type;

endpackage

// ===== rtl/core/blc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface blc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [1:0] new_mode;
   logic [1:0] new_app_state;

   modport source (output valid, output kind, output new_mode, output new_app_state,
                   input ready);
   modport sink   (input valid, input kind, input new_mode, input new_app_state,
                   output ready);
endinterface

// ===== rtl/core/blc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one status word.
// ----------------------------------------------------------------------------
interface blc_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] duty;
   logic [1:0] led_mode;
   logic       rising;

   modport source (output valid, output duty, output led_mode, output rising,
                   input ready);
   modport sink   (input valid, input duty, input led_mode, input rising,
                   output ready);
endinterface

// ===== rtl/core/breathing_led_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breathing LED controller
// LED duty controller with off, full, fast pulse and slow pulse modes.
// ----------------------------------------------------------------------------
// Each request word (tick, mode change or application state) is applied in
// the cycle it is accepted and its status word (duty, mode, direction) shows
// on the response channel in the next cycle. One word per cycle unless the
// response stalls: the only loop, the state update via the level stepper, is
// combinational. Requests are taken whenever the response register is empty
// or being drained. Write the CSRs only while no words are in flight.
`include "assert_macros.svh"

module breathing_led_controller
   import blc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   blc_req_if.sink               req_ch,
   blc_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LEVEL_W-1:0] max_level_ff;
   logic [LEVEL_W-1:0] min_level_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [HOLD_W-1:0]  hold_cfg_ff;
   logic [SDIV_W-1:0]  sdiv_ff;

   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               going_up_ff, going_up_in;
   mode_type           mode_ff, mode_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   app_type            app_ff, app_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_duty_ff, rsp_duty_in;
   mode_type           rsp_mode_ff;
   logic               rsp_rising_ff;

   logic               accept;
   logic               enter_en;
   mode_type           enter_mode;
   logic               step_en;
   logic [SDIV_W-1:0]  sdiv_eff;
   logic [SDIV_W-1:0]  dcnt_next;
   lvl_state_type      step_cur, step_nxt;
   lvl_cfg_type        step_cfg;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign step_cur = '{level: level_ff, going_up: going_up_ff};
   assign step_cfg = '{max_level: max_level_ff, min_level: min_level_ff, step: step_ff};

   blc_level_step u_step (
      .cur (step_cur),
      .cfg (step_cfg),
      .nxt (step_nxt)
   );

   // clamp the slow divider to 1..16
   always_comb begin
      if (sdiv_ff == '0) begin
         sdiv_eff = SDIV_W'(1);
      end else if (sdiv_ff > SDIV_MAX) begin
         sdiv_eff = SDIV_MAX;
      end else begin
         sdiv_eff = sdiv_ff;
      end
   end

   assign dcnt_next = {1'b0, dcnt_ff} + SDIV_W'(1);

   always_comb begin
      level_in    = level_ff;
      going_up_in = going_up_ff;
      mode_in     = mode_ff;
      hold_in     = hold_ff;
      dcnt_in     = dcnt_ff;
      app_in      = app_ff;
      enter_en    = 1'b0;
      enter_mode  = mode_ff;
      step_en     = 1'b0;

      if (accept) begin
         case (kind_type'(req_ch.kind))
            KIND_TICK: begin
               case (mode_ff)
                  MODE_FAST: begin
                     dcnt_in = '0;
                     step_en = 1'b1;
                  end
                  MODE_SLOW: begin
                     if (dcnt_next >= sdiv_eff) begin
                        dcnt_in = '0;
                        step_en = 1'b1;
                     end else begin
                        dcnt_in = dcnt_next[DCNT_W-1:0];
                     end
                  end
                  MODE_FULL: begin
                     if (hold_ff <= HOLD_W'(1)) begin
                        hold_in  = '0;
                        enter_en = 1'b1;
                        case (app_ff)
                           APP_READY:   enter_mode = MODE_SLOW;
                           APP_PROBLEM: enter_mode = MODE_OFF;
                           default:     enter_mode = MODE_FAST;
                        endcase
                     end else begin
                        hold_in = hold_ff - HOLD_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            KIND_MODE: begin
               enter_en   = 1'b1;
               enter_mode = mode_type'(req_ch.new_mode);
            end
            KIND_APP: begin
               app_in = app_type'(req_ch.new_app_state);
            end
            default: begin
            end
         endcase
      end

      if (step_en) begin
         level_in    = step_nxt.level;
         going_up_in = step_nxt.going_up;
      end

      // restart the pattern on entry
      if (enter_en) begin
         mode_in = enter_mode;
         case (enter_mode)
            MODE_OFF:  going_up_in = 1'b1;
            MODE_FULL: hold_in = hold_cfg_ff;
            default: begin
               level_in    = max_level_ff;
               going_up_in = 1'b0;
               dcnt_in     = '0;
            end
         endcase
      end
   end

   always_comb begin
      case (mode_in)
         MODE_OFF:  rsp_duty_in = '0;
         MODE_FULL: rsp_duty_in = FULL_DUTY;
         default:   rsp_duty_in = level_in;
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff <= MAX_LEVEL_RST;
         min_level_ff <= MIN_LEVEL_RST;
         step_ff      <= STEP_RST;
         hold_cfg_ff  <= HOLD_RST;
         sdiv_ff      <= SDIV_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_LEVEL: max_level_ff <= csr_wdata;
            CSR_MIN_LEVEL: min_level_ff <= csr_wdata;
            CSR_STEP:      step_ff      <= csr_wdata[STEP_W-1:0];
            CSR_HOLD:      hold_cfg_ff  <= csr_wdata[HOLD_W-1:0];
            CSR_SLOW_DIV:  sdiv_ff      <= csr_wdata[SDIV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= MAX_LEVEL_RST;
         going_up_ff  <= 1'b0;
         mode_ff      <= MODE_FAST;
         hold_ff      <= HOLD_RST;
         dcnt_ff      <= '0;
         app_ff       <= APP_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         going_up_ff  <= going_up_in;
         mode_ff      <= mode_in;
         hold_ff      <= hold_in;
         dcnt_ff      <= dcnt_in;
         app_ff       <= app_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_duty_ff   <= rsp_duty_in;
         rsp_mode_ff   <= mode_in;
         rsp_rising_ff <= going_up_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.duty     = rsp_duty_ff;
   assign rsp_ch.led_mode = rsp_mode_ff;
   assign rsp_ch.rising   = rsp_rising_ff;

   `BLC_ASSERT(a_no_take_when_stalled, (rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready, "request taken while response stalled")
   `BLC_ASSERT(a_off_dark, (rsp_valid_ff && rsp_mode_ff == MODE_OFF) |-> (rsp_duty_ff == '0), "off mode with nonzero duty")
   `BLC_ASSERT(a_full_bright, (rsp_valid_ff && rsp_mode_ff == MODE_FULL) |-> (rsp_duty_ff == FULL_DUTY), "full mode without full duty")
   `BLC_ASSERT_NEXT(a_pulse_restart, accept && req_ch.kind == KIND_MODE && (req_ch.new_mode == MODE_FAST || req_ch.new_mode == MODE_SLOW), level_ff == max_level_ff && !going_up_ff && dcnt_ff == '0, "pulse entry did not restart")

endmodule

// ===== rtl/core/blc_level_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level stepper
// One saturating step of the triangle level, turning at each end.
// ----------------------------------------------------------------------------
module blc_level_step
   import blc_pkg::*;
(
   input  lvl_state_type cur,
   input  lvl_cfg_type   cfg,
   output lvl_state_type nxt
);

   logic [LEVEL_W:0]   up_sum;
   logic [LEVEL_W-1:0] down_diff;
   logic [LEVEL_W-1:0] step_ext;

   assign step_ext  = LEVEL_W'(cfg.step);
   assign up_sum    = {1'b0, cur.level} + {1'b0, step_ext};
   assign down_diff = cur.level - step_ext;

   always_comb begin
      nxt = cur;
      if (cur.going_up) begin
         if (up_sum >= {1'b0, cfg.max_level}) begin
            nxt.level    = cfg.max_level;
            nxt.going_up = 1'b0;
         end else begin
            nxt.level = up_sum[LEVEL_W-1:0];
         end
      end else begin
         if ((cur.level <= step_ext) || (down_diff <= cfg.min_level)) begin
            nxt.level    = cfg.min_level;
            nxt.going_up = 1'b1;
         end else begin
            nxt.level = down_diff;
         end
      end
   end

endmodule

// ===== tb/sv/tb_breathing_led_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breathing LED controller testbench
// Drives tick, mode, application state and unknown-kind words into the controller and
// checks every status word against an in-bench prediction of the duty, mode
// and direction. Runs a directed opening at reset settings, then random
// phases under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_breathing_led_controller;
   import blc_pkg::*;

   localparam logic [1:0] KIND_NONE   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         REPORT_MAX  = 10;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] new_mode;
      logic [1:0] new_app_state;
   } cmd_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] duty;
      logic [1:0]         led_mode;
      logic               rising;
   } status_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   blc_req_if req_ch ();
   blc_rsp_if rsp_ch ();

   breathing_led_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted register copies
   logic [LEVEL_W-1:0] cfg_max;
   logic [LEVEL_W-1:0] cfg_min;
   logic [STEP_W-1:0]  cfg_step;
   logic [HOLD_W-1:0]  cfg_hold;
   logic [SDIV_W-1:0]  cfg_sdiv;

   // predicted controller state
   logic [LEVEL_W-1:0] lvl;
   logic               climbing;
   mode_type           cur_mode;
   logic [HOLD_W-1:0]  hold_left;
   logic [DCNT_W-1:0]  div_count;
   app_type            app;

   cmd_word_type pending_words[$];
   status_type   expected_status[$];

   int unsigned words_queued = 0;
   int unsigned words_taken  = 0;
   int unsigned idle_pct     = 10;
   int unsigned failures     = 0;
   int unsigned checked      = 0;
   int unsigned cycle_count  = 0;
   int unsigned n_ticks      = 0;
   int unsigned n_modes      = 0;
   int unsigned n_apps       = 0;
   int unsigned n_ignored    = 0;
   int unsigned settings_run = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void enter_mode(mode_type m);
      cur_mode = m;
      case (m)
         MODE_OFF: begin
            climbing = 1'b1;
         end
         MODE_FULL: begin
            hold_left = cfg_hold;
         end
         default: begin
            lvl       = cfg_max;
            climbing  = 1'b0;
            div_count = '0;
         end
      endcase
   endfunction

   function automatic void step_level();
      int unsigned l;
      int unsigned s;
      l = lvl;
      s = cfg_step;
      if (climbing) begin
         if (l + s >= cfg_max) begin
            lvl      = cfg_max;
            climbing = 1'b0;
         end else begin
            lvl = LEVEL_W'(l + s);
         end
      end else begin
         if (l <= s || l - s <= cfg_min) begin
            lvl      = cfg_min;
            climbing = 1'b1;
         end else begin
            lvl = LEVEL_W'(l - s);
         end
      end
   endfunction

   function automatic status_type apply_word(cmd_word_type w);
      status_type  st;
      int unsigned div;
      case (w.kind)
         KIND_TICK: begin
            case (cur_mode)
               MODE_FAST: begin
                  div_count = '0;
                  step_level();
               end
               MODE_SLOW: begin
                  div = cfg_sdiv;
                  if (div == 0) div = 1;
                  if (div > SDIV_MAX) div = SDIV_MAX;
                  if (div_count + 1 >= div) begin
                     div_count = '0;
                     step_level();
                  end else begin
                     div_count = div_count + 1'b1;
                  end
               end
               MODE_FULL: begin
                  if (hold_left <= 1) begin
                     hold_left = '0;
                     case (app)
                        APP_READY:   enter_mode(MODE_SLOW);
                        APP_PROBLEM: enter_mode(MODE_OFF);
                        default:     enter_mode(MODE_FAST);
                     endcase
                  end else begin
                     hold_left = hold_left - 1'b1;
                  end
               end
               default: ;
            endcase
         end
         KIND_MODE: enter_mode(mode_type'(w.new_mode));
         KIND_APP:  app = app_type'(w.new_app_state);
         default: ;
      endcase
      case (cur_mode)
         MODE_OFF:  st.duty = '0;
         MODE_FULL: st.duty = FULL_DUTY;
         default:   st.duty = lvl;
      endcase
      st.led_mode = cur_mode;
      st.rising   = climbing;
      return st;
   endfunction

   task automatic queue_word(logic [1:0] kind, logic [1:0] m, logic [1:0] a);
      cmd_word_type w;
      w.kind          = kind;
      w.new_mode      = m;
      w.new_app_state = a;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_MAX_LEVEL: cfg_max  = LEVEL_W'(value);
         CSR_MIN_LEVEL: cfg_min  = LEVEL_W'(value);
         CSR_STEP:      cfg_step = STEP_W'(value);
         CSR_HOLD:      cfg_hold = HOLD_W'(value);
         default:       cfg_sdiv = SDIV_W'(value);
      endcase
   endtask

   task automatic wait_drained();
      while (words_taken != words_queued || expected_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly well-formed bursts (state, mode, run of ticks), some loose words
   task automatic queue_random_words(int unsigned count);
      int unsigned queued;
      int unsigned run;
      int unsigned pick;
      logic [1:0]  k;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(9) < 7) begin
            if ($urandom_range(1) == 1) begin
               queue_word(KIND_APP, 2'($urandom_range(3)), 2'($urandom_range(3)));
               queued++;
            end
            queue_word(KIND_MODE, 2'($urandom_range(3)), 2'($urandom_range(3)));
            queued++;
            pick = $urandom_range(15);
            if (pick == 0)
               run = $urandom_range(1, int'(cfg_hold) + 3);
            else if (pick == 1)
               run = $urandom_range(40, 160);
            else
               run = $urandom_range(1, 24);
            repeat (run)
               queue_word(KIND_TICK, 2'($urandom_range(3)), 2'($urandom_range(3)));
            queued += run;
         end else begin
            k = 2'($urandom_range(3));
            queue_word(k, 2'($urandom_range(3)), 2'($urandom_range(3)));
            if (k != KIND_NONE) queued++;
         end
      end
   endtask

   task automatic run_phase(int unsigned mx, int unsigned mn, int unsigned stp,
                            int unsigned hld, int unsigned sdv, int unsigned count);
      write_csr(CSR_MAX_LEVEL, mx);
      write_csr(CSR_MIN_LEVEL, mn);
      write_csr(CSR_STEP, stp);
      write_csr(CSR_HOLD, hld);
      write_csr(CSR_SLOW_DIV, sdv);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_run++;
      queue_random_words(count);
      wait_drained();
   endtask

   // driver: predict on acceptance, then load the next word or drop valid
   always @(posedge clock) begin
      cmd_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            w.kind          = req_ch.kind;
            w.new_mode      = req_ch.new_mode;
            w.new_app_state = req_ch.new_app_state;
            expected_status.push_back(apply_word(w));
            words_taken++;
            case (w.kind)
               KIND_TICK: n_ticks++;
               KIND_MODE: n_modes++;
               KIND_APP:  n_apps++;
               default:   n_ignored++;
            endcase
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               w = pending_words.pop_front();
               req_ch.valid         <= 1'b1;
               req_ch.kind          <= w.kind;
               req_ch.new_mode      <= w.new_mode;
               req_ch.new_app_state <= w.new_app_state;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each status word with the oldest prediction
   always @(posedge clock) begin
      status_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_status.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX)
                  $display("unexpected status word: duty %0d mode %0d rising %0b",
                           rsp_ch.duty, rsp_ch.led_mode, rsp_ch.rising);
            end else begin
               want = expected_status.pop_front();
               if (rsp_ch.duty !== want.duty || rsp_ch.led_mode !== want.led_mode ||
                   rsp_ch.rising !== want.rising) begin
                  failures++;
                  if (failures <= REPORT_MAX)
                     $display("status word %0d: expected duty %0d mode %0d rising %0b, %s %0d %0d %0b",
                              checked, want.duty, want.led_mode, want.rising, "got",
                              rsp_ch.duty, rsp_ch.led_mode, rsp_ch.rising);
               end
            end
            checked++;
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d predictions pending",
                  cycle_count, expected_status.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int unsigned mx;
      int unsigned mn;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.kind          = '0;
      req_ch.new_mode      = '0;
      req_ch.new_app_state = '0;
      rsp_ch.ready         = 1'b0;

      cfg_max   = MAX_LEVEL_RST;
      cfg_min   = MIN_LEVEL_RST;
      cfg_step  = STEP_RST;
      cfg_hold  = HOLD_RST;
      cfg_sdiv  = SDIV_RST;
      lvl       = MAX_LEVEL_RST;
      climbing  = 1'b0;
      cur_mode  = MODE_FAST;
      hold_left = HOLD_RST;
      div_count = '0;
      app       = APP_INIT;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed opening at reset settings
      queue_word(KIND_TICK, MODE_OFF, APP_INIT);
      queue_word(KIND_NONE, MODE_FULL, APP_PROBLEM);
      queue_word(KIND_MODE, MODE_SLOW, APP_INIT);
      repeat (4) queue_word(KIND_TICK, MODE_OFF, APP_INIT);
      queue_word(KIND_APP, MODE_OFF, APP_READY);
      queue_word(KIND_MODE, MODE_FULL, APP_INIT);
      repeat (4) queue_word(KIND_TICK, MODE_OFF, APP_INIT);
      queue_word(KIND_APP, MODE_OFF, APP_PROBLEM);
      queue_word(KIND_MODE, MODE_FULL, APP_INIT);
      repeat (4) queue_word(KIND_TICK, MODE_OFF, APP_INIT);
      queue_word(KIND_TICK, MODE_FULL, APP_PROBLEM);
      queue_word(KIND_MODE, MODE_OFF, APP_INIT);
      queue_word(KIND_MODE, MODE_FAST, APP_INIT);
      settings_run++;
      wait_drained();

      run_phase(1023, 0, 15, 1, 1, 100);
      run_phase(0, 0, 1, 255, 16, 100);
      run_phase(5, 1000, 7, 0, 0, 100);
      run_phase(600, 100, 0, 3, 31, 100);
      idle_pct = 0;
      run_phase(300, 20, 3, 2, 2, 200);
      idle_pct = 10;
      repeat (4) begin
         if ($urandom_range(3) == 0) begin
            mx = $urandom_range(1023);
            mn = $urandom_range(1023);
         end else begin
            mx = $urandom_range(300, 1023);
            mn = $urandom_range(0, 299);
         end
         run_phase(mx, mn, $urandom_range(15),
                   ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 12),
                   $urandom_range(31), 75);
      end

      $display("covered %0d ticks, %0d mode changes, %0d state updates, %0d unknown kinds",
               n_ticks, n_modes, n_apps, n_ignored);
      $display("over %0d register settings; %0d status words checked, %0d failures",
               settings_run, checked, failures);
      if (failures == 0 && expected_status.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
